// File: hw/rtl/blob_endian_swap_stream_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the blob byte-order converter
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef BLOB_ENDIAN_SWAP_STREAM_UNIT_MACROS_SVH
`define BLOB_ENDIAN_SWAP_STREAM_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define BESS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define BESS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BESS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bess_pkg.sv
// ----------------------------------------------------------------------------
// bess_pkg
// Types and constants shared by the blob byte-order converter.
// ----------------------------------------------------------------------------
package bess_pkg;

  localparam int POSITION_BITS_DEF = 24;
  localparam int ADDR_BITS         = 32;
  // region ends: 32-bit start plus up to 20 times a 32-bit count
  localparam int END_BITS          = 38;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [7:0]  HEADER_SIZE   = 8'h1c;
  localparam logic [7:0]  HDR_WORD_POS  = 8'h04;
  localparam logic [7:0]  HDR_CHECK_POS = 8'h07;
  localparam logic [7:0]  FIELD_FIRST   = 8'h08;
  localparam logic [7:0]  LAST_FIELD    = 8'h17;
  localparam logic [4:0]  ENTRY_SIZE    = 5'd20;
  localparam logic [4:0]  ENTRY_SWAPPED = 5'd16;
  localparam logic [31:0] MAGIC         = 32'h5350_4342;
  localparam logic [1:0]  LANE_TOP      = 2'd3;

  localparam logic [2:0] ST_SWAPPED   = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_HOST      = 3'd2;
  localparam logic [2:0] ST_LAYOUT    = 3'd3;
  localparam logic [2:0] ST_REGION    = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_blob;
    logic [2:0] status;
  } out_beat_t;

  // one classified input byte on its way to the back end
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] status;
    logic       swap;
    logic [1:0] lane;
  } rec_t;

endpackage

// File: hw/rtl/bess_front.sv
// ----------------------------------------------------------------------------
// bess_front
// Tracks the byte position, checks the header, captures the region fields
// and tags every byte with its lane within a word to be reversed.
// ----------------------------------------------------------------------------
`include "blob_endian_swap_stream_unit_macros.svh"

module bess_front #(
  parameter int POSITION_BITS = bess_pkg::POSITION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  bess_pkg::in_beat_t in_data,
  output logic               push,
  output bess_pkg::rec_t     rec
);

  localparam int PB = POSITION_BITS;
  localparam int EB = bess_pkg::END_BITS;
  localparam int AB = bess_pkg::ADDR_BITS;
  localparam logic [PB-1:0] POS_LIMIT = '1;
  localparam logic [EB-1:0] LIMIT_E   = EB'(POS_LIMIT);
  localparam logic [EB-1:0] HDR_E     = EB'(bess_pkg::HEADER_SIZE);
  localparam logic [31:0]   HDR_WORD  = 32'(bess_pkg::HEADER_SIZE);

  logic [PB-1:0] pos_r, pos_nxt;
  logic [AB-1:0] ds_r, ds_nxt, dwc_r, dwc_nxt, ss_r, ss_nxt, sec_r, sec_nxt;
  logic [4:0]    phase_r, phase_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [23:0]   hdr_r;
  logic [EB-1:0] de_r, se_r, se_hi_r;

  logic [7:0]    b;
  logic          last;
  logic [7:0]    magic_b;
  logic [EB-1:0] p_e, ds_e, ss_e, se17, hi_y;
  logic [AB-1:0] sec_full;
  logic          dn, sn17, regions_bad;
  logic [31:0]   hdr_be, hdr_le;
  logic [4:0]    sym_off;
  logic          swap;
  logic [1:0]    lane;

  assign b    = in_data.in_byte;
  assign last = in_data.last_byte;
  assign push = in_valid && in_ready;

  assign magic_b = bess_pkg::MAGIC[{~pos_r[1:0], 3'b000} +: 8];

  assign p_e  = EB'(pos_r);
  assign ds_e = EB'(ds_r);
  assign ss_e = EB'(ss_r);

  // symbol end at the last count byte: partial end from the previous byte
  // plus twenty times this byte
  assign sec_full = {sec_r[23:0], b};
  assign se17     = se_hi_r + EB'({b, 4'h0}) + EB'({b, 2'h0});
  assign dn       = dwc_r != '0;
  assign sn17     = sec_full != '0;
  assign regions_bad =
      (dn && (ds_e < HDR_E || de_r > LIMIT_E)) ||
      (sn17 && (ss_e < HDR_E || se17 > LIMIT_E)) ||
      (dn && sn17 && ds_e < se17 && ss_e < de_r);

  assign hdr_be = {hdr_r, b};
  assign hdr_le = {b, hdr_r[7:0], hdr_r[15:8], hdr_r[23:16]};

  assign sym_off = (p_e == ss_e) ? 5'd0 : phase_r;
  assign hi_y    = EB'({sec_r[15:0], b, 8'h00});

  always_comb begin
    status_nxt = status_r;
    ds_nxt     = ds_r;
    dwc_nxt    = dwc_r;
    ss_nxt     = ss_r;
    sec_nxt    = sec_r;
    phase_nxt  = phase_r;
    swap       = 1'b0;
    lane       = 2'd0;

    if (pos_r < PB'(bess_pkg::HDR_WORD_POS) && status_r == bess_pkg::ST_SWAPPED &&
        b != magic_b) begin
      status_nxt = bess_pkg::ST_BAD_MAGIC;
    end

    if (pos_r >= PB'(bess_pkg::FIELD_FIRST) && pos_r <= PB'(bess_pkg::LAST_FIELD)) begin
      unique case (pos_r[4:2])
        3'd2:    ds_nxt  = {ds_r[23:0], b};
        3'd3:    dwc_nxt = {dwc_r[23:0], b};
        3'd4:    ss_nxt  = {ss_r[23:0], b};
        3'd5:    sec_nxt = sec_full;
        default: ;
      endcase
    end

    if (pos_r >= PB'(bess_pkg::HDR_WORD_POS) && pos_r < PB'(bess_pkg::HEADER_SIZE)) begin
      lane = pos_r[1:0];
      if (pos_r == PB'(bess_pkg::HDR_CHECK_POS) && status_nxt == bess_pkg::ST_SWAPPED &&
          hdr_be != HDR_WORD) begin
        status_nxt = (hdr_le == HDR_WORD) ? bess_pkg::ST_HOST : bess_pkg::ST_LAYOUT;
      end
      if (pos_r == PB'(bess_pkg::LAST_FIELD) && status_nxt == bess_pkg::ST_SWAPPED &&
          regions_bad) begin
        status_nxt = bess_pkg::ST_REGION;
      end
      swap = status_nxt == bess_pkg::ST_SWAPPED || status_nxt == bess_pkg::ST_REGION;
    end else if (pos_r >= PB'(bess_pkg::HEADER_SIZE) && pos_r != POS_LIMIT &&
                 status_nxt == bess_pkg::ST_SWAPPED) begin
      if (p_e >= ds_e && p_e < de_r) begin
        lane = pos_r[1:0] - ds_r[1:0];
        swap = 1'b1;
      end else if (p_e >= ss_e && p_e < se_r) begin
        phase_nxt = (sym_off + 5'd1 >= bess_pkg::ENTRY_SIZE) ? 5'd0 : sym_off + 5'd1;
        // trailing word of an entry passes through
        if (sym_off < bess_pkg::ENTRY_SWAPPED) begin
          lane = sym_off[1:0];
          swap = 1'b1;
        end
      end
    end

    if (last && status_nxt == bess_pkg::ST_SWAPPED) begin
      if (pos_r < PB'(bess_pkg::HEADER_SIZE - 8'd1)) begin
        if (pos_r < PB'(bess_pkg::HDR_WORD_POS)) begin
          status_nxt = bess_pkg::ST_BAD_MAGIC;
        end else if (pos_r < PB'(bess_pkg::FIELD_FIRST)) begin
          status_nxt = bess_pkg::ST_LAYOUT;
        end else begin
          status_nxt = bess_pkg::ST_REGION;
        end
      end else if ((dn && de_r > p_e + EB'(1)) ||
                   (sec_r != '0 && se_r > p_e + EB'(1))) begin
        status_nxt = bess_pkg::ST_REGION;
      end
    end
  end

  assign pos_nxt = (pos_r != POS_LIMIT) ? pos_r + PB'(1) : pos_r;

  always_comb begin
    rec.data   = b;
    rec.last   = last;
    rec.status = status_nxt;
    rec.swap   = swap;
    rec.lane   = lane;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      ds_r     <= '0;
      dwc_r    <= '0;
      ss_r     <= '0;
      sec_r    <= '0;
      phase_r  <= '0;
      status_r <= bess_pkg::ST_SWAPPED;
    end else if (push) begin
      if (last) begin
        pos_r    <= '0;
        ds_r     <= '0;
        dwc_r    <= '0;
        ss_r     <= '0;
        sec_r    <= '0;
        phase_r  <= '0;
        status_r <= bess_pkg::ST_SWAPPED;
      end else begin
        pos_r    <= pos_nxt;
        ds_r     <= ds_nxt;
        dwc_r    <= dwc_nxt;
        ss_r     <= ss_nxt;
        sec_r    <= sec_nxt;
        phase_r  <= phase_nxt;
        status_r <= status_nxt;
      end
    end
  end

  // region ends are registered from the captured fields; first read well after capture
  always_ff @(posedge clk) begin
    de_r <= ds_e + (EB'(dwc_r) << 2);
    se_r <= ss_e + (EB'(sec_r) << 4) + (EB'(sec_r) << 2);
    if (push) begin
      hdr_r   <= {hdr_r[15:0], b};
      se_hi_r <= ss_e + (hi_y << 4) + (hi_y << 2);
    end
  end

  `BESS_ASSERT_NEXT(a_status_sticky,
    push && !last && status_r != bess_pkg::ST_SWAPPED, status_r == $past(status_r),
    "rejection status changed within a blob")
  `BESS_ASSERT_NEXT(a_blob_restart, push && last, pos_r == '0 && phase_r == '0,
    "position not restarted after final beat")

endmodule

// File: hw/rtl/bess_fifo.sv
// ----------------------------------------------------------------------------
// bess_fifo
// Short queue of classified bytes between front and back end.
// ----------------------------------------------------------------------------
`include "blob_endian_swap_stream_unit_macros.svh"

module bess_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bess_pkg::rec_t wr_rec,
  output logic           wr_ready,
  input  logic           pop,
  output bess_pkg::rec_t head,
  output logic           head_valid
);

  localparam int PW = bess_pkg::QPTR_BITS;
  localparam logic [PW:0] CNT_DEPTH = (PW + 1)'(bess_pkg::QUEUE_DEPTH);

  bess_pkg::rec_t mem_r [bess_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PW:0]    cnt_r;

  assign wr_ready   = cnt_r != CNT_DEPTH;
  assign head_valid = cnt_r != '0;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      cnt_r <= cnt_r + (PW + 1)'(push) - (PW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_rec;
  end

  `BESS_ASSERT_ALWAYS(a_fifo_bound, cnt_r <= CNT_DEPTH, "queue count beyond depth")
  `BESS_ASSERT_IMPL(a_fifo_pop, pop, head_valid, "pop from an empty queue")

endmodule

// File: hw/rtl/bess_back.sv
// ----------------------------------------------------------------------------
// bess_back
// Holds the bytes of a word in progress, reverses completed words and
// sends the resulting bytes out one beat per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`include "blob_endian_swap_stream_unit_macros.svh"

module bess_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bess_pkg::rec_t      head,
  input  logic                head_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output bess_pkg::out_beat_t out_data
);

  logic [7:0] held_r [3];
  logic [7:0] held_nxt [3];
  logic [1:0] hc_r, hc_nxt;

  logic [7:0] buf_r [4];
  logic [7:0] list [4];
  logic [2:0] left_r, n;
  logic [2:0] stat_r;
  logic       last_r;

  logic pure_hold, can_load, load, out_fire;

  always_comb begin
    for (int i = 0; i < 4; i++) list[i] = 8'h00;
    for (int i = 0; i < 3; i++) held_nxt[i] = held_r[i];
    hc_nxt    = hc_r;
    n         = 3'd0;
    pure_hold = 1'b0;

    if (head.swap && head.lane == bess_pkg::LANE_TOP && hc_r == bess_pkg::LANE_TOP) begin
      list[0] = head.data;
      list[1] = held_r[2];
      list[2] = held_r[1];
      list[3] = held_r[0];
      n       = 3'd4;
      hc_nxt  = 2'd0;
    end else if (head.swap && head.lane != bess_pkg::LANE_TOP && !head.last) begin
      // out-of-step lane: flush what is held first
      if (hc_r != head.lane) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < hc_r) list[i] = held_r[i];
        end
        n = {1'b0, hc_r};
      end else begin
        pure_hold = 1'b1;
      end
      held_nxt[head.lane] = head.data;
      hc_nxt              = head.lane + 2'd1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < hc_r) list[i] = held_r[i];
      end
      list[hc_r] = head.data;
      n          = {1'b0, hc_r} + 3'd1;
      hc_nxt     = 2'd0;
    end

    if (head.last) begin
      for (int i = 0; i < 3; i++) held_nxt[i] = 8'h00;
      hc_nxt = 2'd0;
    end
  end

  // pure holds retire while the buffer is still draining
  assign can_load  = left_r == 3'd0 || (left_r == 3'd1 && out_ready);
  assign pop       = head_valid && (pure_hold || can_load);
  assign load      = head_valid && !pure_hold && can_load;
  assign out_valid = left_r != 3'd0;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    out_data.out_byte    = buf_r[0];
    out_data.end_of_blob = last_r && left_r == 3'd1;
    out_data.status      = stat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= 2'd0;
      for (int i = 0; i < 3; i++) held_r[i] <= 8'h00;
    end else if (pop) begin
      hc_r <= hc_nxt;
      for (int i = 0; i < 3; i++) held_r[i] <= held_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 3'd0;
    end else if (load) begin
      left_r <= n;
    end else if (out_fire) begin
      left_r <= left_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 4; i++) buf_r[i] <= list[i];
      stat_r <= head.status;
      last_r <= head.last;
    end else if (out_fire) begin
      for (int i = 0; i < 3; i++) buf_r[i] <= buf_r[i + 1];
    end
  end

  `BESS_ASSERT_ALWAYS(a_buf_bound, left_r <= 3'd4, "output buffer count beyond a word")
  `BESS_ASSERT_NEXT(a_held_clear, pop && head.last, hc_r == 2'd0 && held_r[0] == 8'h00,
    "held bytes survive the end of a blob")

endmodule

// File: hw/rtl/blob_endian_swap_stream_unit.sv
// ----------------------------------------------------------------------------
// blob_endian_swap_stream_unit
// Streaming byte-order converter for SPCB blobs, one byte per beat.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------
//  input    | in_valid / in_ready | in_data  : in_byte, last_byte
//  output   | out_valid/out_ready | out_data : out_byte, end_of_blob, status
//
// One byte is taken per cycle while the four-entry queue has room, and one
// byte leaves per cycle from the output buffer while out_ready is high. A
// word is reversed once its last byte reaches the head of the queue.
// Reset clears position, status and queue; no clearing pass is needed.
// Either side may stall on its own: the queue absorbs the difference.
// ----------------------------------------------------------------------------
module blob_endian_swap_stream_unit #(
  parameter int POSITION_BITS = bess_pkg::POSITION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bess_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bess_pkg::out_beat_t out_data
);

  logic           push, pop, head_valid;
  bess_pkg::rec_t wr_rec, head;

  bess_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .push    (push),
    .rec     (wr_rec)
  );

  bess_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_rec    (wr_rec),
    .wr_ready  (in_ready),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid)
  );

  bess_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
